>>> hdl/dust_sensor_frame_receiver_core_defines.svh
// assertion macros of the dust sensor frame receiver, used by dsfr_frame
// no dependencies; taken in by `include where assertions are written
`ifndef DUST_SENSOR_FRAME_RECEIVER_CORE_DEFINES_SVH
`define DUST_SENSOR_FRAME_RECEIVER_CORE_DEFINES_SVH

// condition in the same cycle
`define DSFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition in the following cycle
`define DSFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/dsfr_pkg.sv
// shared types and constants of the dust sensor frame receiver
// no dependencies; used by every module of the block
`default_nettype none

package dsfr_pkg;

  localparam int FRAME_BYTES = 9;
  localparam logic [3:0] LAST_POS = 4'(FRAME_BYTES - 1);
  localparam logic [7:0] REPLY_TYPE_DATA = 8'h02;

  localparam logic [7:0]  IDLE_LIMIT_RST   = 8'd2;
  localparam logic [15:0] FINE_LIMIT_RST   = 16'd999;
  localparam logic [15:0] COARSE_LIMIT_RST = 16'd1500;

  typedef enum logic [1:0] {
    REG_IDLE_LIMIT   = 2'd0,
    REG_FINE_LIMIT   = 2'd1,
    REG_COARSE_LIMIT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_SUM  = 2'd1,
    STATUS_BAD_TYPE = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  idle_limit;
    logic [15:0] fine_limit;
    logic [15:0] coarse_limit;
  } cfg_t;

  typedef struct packed {
    logic       func;     // 1 timer tick, 0 received byte
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] fine_reading;
    logic [15:0] coarse_reading;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/dsfr_cfg_regs.sv
// configuration registers: idle limit and the two reading clamps
// depends on dsfr_pkg
`default_nettype none

module dsfr_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [1:0]    wr_index,
  input  wire logic [15:0]   wr_data,
  output dsfr_pkg::cfg_t     cfg
);

  dsfr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_limit   <= dsfr_pkg::IDLE_LIMIT_RST;
      cfg_r.fine_limit   <= dsfr_pkg::FINE_LIMIT_RST;
      cfg_r.coarse_limit <= dsfr_pkg::COARSE_LIMIT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        dsfr_pkg::REG_IDLE_LIMIT:   cfg_r.idle_limit   <= wr_data[7:0];
        dsfr_pkg::REG_FINE_LIMIT:   cfg_r.fine_limit   <= wr_data;
        dsfr_pkg::REG_COARSE_LIMIT: cfg_r.coarse_limit <= wr_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hdl/dsfr_frame.sv
// frame assembly, idle timeout, checksum and type check, clamped readings
// depends on dsfr_pkg and dust_sensor_frame_receiver_core_defines.svh
`default_nettype none
`include "dust_sensor_frame_receiver_core_defines.svh"

module dsfr_frame (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire dsfr_pkg::item_t  item,
  input  wire dsfr_pkg::cfg_t   cfg,
  output logic                  res_valid,
  output dsfr_pkg::result_t     res
);

  logic [3:0]  pos_r,    pos_nxt;
  logic [7:0]  idle_r,   idle_nxt;
  logic [15:0] sum_r,    sum_nxt;
  logic [7:0]  rtype_r,  rtype_nxt;
  logic [15:0] check_r,  check_nxt;
  logic [15:0] coarse_raw_r, coarse_raw_nxt;
  logic [15:0] fine_raw_r,   fine_raw_nxt;
  logic [15:0] kept_fine_r,   kept_fine_nxt;
  logic [15:0] kept_coarse_r, kept_coarse_nxt;

  logic [8:0]  tick_cnt;
  logic [15:0] sum_add;
  logic        last_byte;
  dsfr_pkg::status_t status;

  assign tick_cnt  = {1'b0, idle_r} + 9'd1;
  assign sum_add   = sum_r + {8'd0, item.rx_byte};
  assign last_byte = step && !item.func && (pos_r >= dsfr_pkg::LAST_POS);

  always_comb begin
    pos_nxt         = pos_r;
    idle_nxt        = idle_r;
    sum_nxt         = sum_r;
    rtype_nxt       = rtype_r;
    check_nxt       = check_r;
    coarse_raw_nxt  = coarse_raw_r;
    fine_raw_nxt    = fine_raw_r;
    kept_fine_nxt   = kept_fine_r;
    kept_coarse_nxt = kept_coarse_r;
    status          = dsfr_pkg::STATUS_OK;

    if (step && item.func) begin
      if (tick_cnt > {1'b0, cfg.idle_limit}) begin
        pos_nxt  = '0;
        idle_nxt = '0;
      end else begin
        idle_nxt = tick_cnt[7:0];
      end
    end else if (step) begin
      idle_nxt = '0;
      unique case (pos_r)
        4'd0: sum_nxt = {8'd0, item.rx_byte};
        4'd1: begin
          sum_nxt   = sum_add;
          rtype_nxt = item.rx_byte;
        end
        4'd2: begin
          sum_nxt        = sum_add;
          coarse_raw_nxt = {item.rx_byte, 8'd0};
        end
        4'd3: begin
          sum_nxt        = sum_add;
          coarse_raw_nxt = {coarse_raw_r[15:8], item.rx_byte};
        end
        4'd4: begin
          sum_nxt      = sum_add;
          fine_raw_nxt = {item.rx_byte, 8'd0};
        end
        4'd5: begin
          sum_nxt      = sum_add;
          fine_raw_nxt = {fine_raw_r[15:8], item.rx_byte};
        end
        4'd6: check_nxt = {item.rx_byte, 8'd0};
        4'd7: check_nxt = {check_r[15:8], item.rx_byte};
        default: sum_nxt = sum_add;
      endcase

      if (last_byte) begin
        pos_nxt = '0;
        // checksum mismatch wins over a wrong reply type
        priority if (sum_add != check_r) begin
          status = dsfr_pkg::STATUS_BAD_SUM;
        end else if (rtype_r != dsfr_pkg::REPLY_TYPE_DATA) begin
          status = dsfr_pkg::STATUS_BAD_TYPE;
        end else begin
          status          = dsfr_pkg::STATUS_OK;
          kept_fine_nxt   = (fine_raw_r > cfg.fine_limit) ? cfg.fine_limit : fine_raw_r;
          kept_coarse_nxt = (coarse_raw_r > cfg.coarse_limit) ? cfg.coarse_limit
                                                               : coarse_raw_r;
        end
      end else begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      idle_r        <= '0;
      sum_r         <= '0;
      rtype_r       <= '0;
      check_r       <= '0;
      coarse_raw_r  <= '0;
      fine_raw_r    <= '0;
      kept_fine_r   <= '0;
      kept_coarse_r <= '0;
    end else begin
      pos_r         <= pos_nxt;
      idle_r        <= idle_nxt;
      sum_r         <= sum_nxt;
      rtype_r       <= rtype_nxt;
      check_r       <= check_nxt;
      coarse_raw_r  <= coarse_raw_nxt;
      fine_raw_r    <= fine_raw_nxt;
      kept_fine_r   <= kept_fine_nxt;
      kept_coarse_r <= kept_coarse_nxt;
    end
  end

  assign res_valid          = last_byte;
  assign res.status         = status;
  assign res.fine_reading   = kept_fine_nxt;
  assign res.coarse_reading = kept_coarse_nxt;

  `DSFR_ASSERT_SAME(a_pos_in_frame, clk, rst_n, 1'b1, pos_r <= dsfr_pkg::LAST_POS,
    "frame position past last byte")
  `DSFR_ASSERT_NEXT(a_pos_wraps, clk, rst_n, last_byte, pos_r == 4'd0,
    "frame position did not restart after last byte")
  `DSFR_ASSERT_NEXT(a_reject_keeps, clk, rst_n,
    res_valid && (status != dsfr_pkg::STATUS_OK),
    $stable(kept_fine_r) && $stable(kept_coarse_r),
    "rejected frame changed kept readings")
  `DSFR_ASSERT_NEXT(a_idle_bounded, clk, rst_n, step && item.func,
    idle_r <= $past(cfg.idle_limit), "idle count above limit after tick")

endmodule

`default_nettype wire

>>> hdl/dust_sensor_frame_receiver_core.sv
// Dust sensor frame receiver: takes received bytes and timer ticks as input beats,
// assembles 9-byte sensor reply frames and gives one result beat per frame with
// the status and the clamped PM2.5 and PM10 readings kept from the last good frame.
// One input beat is accepted per clock; the beat that carries the ninth byte is held
// in the input register, and its result then in the result register. Input
// stalls only while the result register is full and out_tready is low.
// Configuration writes are always ready and should be made while the block is idle.
// Depends on dsfr_pkg, dsfr_cfg_regs and dsfr_frame.
`default_nettype none

module dust_sensor_frame_receiver_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tuser,   // [0] func: 1 tick, 0 byte
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [1:0] status, [17:2] fine_reading,
                                       // [33:18] coarse_reading, [39:34] zero
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  dsfr_pkg::cfg_t    cfg;
  dsfr_pkg::item_t   in_item_r;
  dsfr_pkg::result_t res, out_res_r;
  logic              in_valid_r;
  logic              out_valid_r;
  logic              out_free;
  logic              advance;
  logic              res_valid;

  assign cfg_ready = 1'b1;

  dsfr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.func    <= in_tuser;
      in_item_r.rx_byte <= in_tdata;
    end
  end

  dsfr_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (in_item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.coarse_reading, out_res_r.fine_reading,
                       out_res_r.status};

endmodule

`default_nettype wire
